FILE: hw/rtl/lscr_pkg.sv
// Shared types and constants for the line scan camera readout core.
package lscr_pkg;

	// Field widths fixed by the item format
	localparam int TIME_W   = 16;
	localparam int SAMPLE_W = 12;
	localparam int INDEX_W  = 7;

	// Default number of pixels in one sensor line
	localparam int PIXEL_COUNT_DEF = 128;

	// Line step at which the first pixel is captured
	localparam int FIRST_PIXEL_STEP = 2;

	// Configuration port
	localparam int             APB_ADDR_W      = 3;
	localparam int             APB_DATA_W      = 32;
	localparam logic           REG_FRAME_PERIOD = 1'b0;
	localparam logic [TIME_W-1:0] PERIOD_RESET = TIME_W'(60);

	// One result item
	typedef struct packed {
		logic                sensor_clock;
		logic                start_pulse;
		logic                pixel_valid;
		logic [INDEX_W-1:0]  pixel_index;
		logic [SAMPLE_W-1:0] pixel_value;
		logic                line_done;
	} result_t;

endpackage

FILE: hw/rtl/lscr_cfg.sv
// APB register file holding the frame period.
module lscr_cfg
	import lscr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [TIME_W-1:0]     frame_period
);

	logic              wr_en;
	logic              reg_hit;
	logic [TIME_W-1:0] period_q;

	// Register index is the word address; low byte bits are ignored
	assign reg_hit = (paddr[APB_ADDR_W-1] == REG_FRAME_PERIOD);
	assign wr_en   = psel && penable && pwrite && reg_hit;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (wr_en) begin
			period_q <= pwdata[TIME_W-1:0];
		end
	end

	// Read back
	assign prdata       = reg_hit ? APB_DATA_W'(period_q) : '0;
	assign frame_period = period_q;

endmodule

FILE: hw/rtl/lscr_seq.sv
// Sensor sequencer: clock toggle, frame timing, line step and pixel capture.
module lscr_seq
	import lscr_pkg::*;
#(
	parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [TIME_W-1:0]   now_ms,
	input  logic [SAMPLE_W-1:0] adc_sample,
	input  logic [TIME_W-1:0]   frame_period,
	output result_t             res
);

	localparam int STEP_W = $clog2(PIXEL_COUNT + 2);
	localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(PIXEL_COUNT + 1);
	localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(FIRST_PIXEL_STEP);
	localparam logic [STEP_W-1:0] START_STEP = STEP_W'(1);

	logic              clock_q, clock_nxt;
	logic              start_q, start_nxt;
	logic [STEP_W-1:0] step_q, step_nxt;
	logic [TIME_W-1:0] mark_q, mark_nxt;
	logic [TIME_W-1:0] elapsed;
	logic [STEP_W-1:0] pix_pos;
	logic [STEP_W+INDEX_W-1:0] pix_pos_ext;

	assign elapsed     = now_ms - mark_q;
	assign pix_pos     = step_q - FIRST_STEP;
	assign pix_pos_ext = {{INDEX_W{1'b0}}, pix_pos};

	// Next state and result for one tick
	always_comb begin
		clock_nxt = ~clock_q;
		start_nxt = start_q;
		step_nxt  = step_q;
		mark_nxt  = mark_q;
		res       = '0;
		if (clock_q) begin
			if (step_q == '0) begin
				// idle: start a line once the period has strictly elapsed
				if (elapsed > frame_period) begin
					mark_nxt  = mark_q + frame_period;
					step_nxt  = START_STEP;
					start_nxt = 1'b1;
				end
			end else begin
				start_nxt = 1'b0;
			end
		end else if (step_q != '0) begin
			if (step_q >= FIRST_STEP) begin
				res.pixel_valid = 1'b1;
				res.pixel_index = pix_pos_ext[INDEX_W-1:0];
				res.pixel_value = adc_sample;
			end
			if (step_q < LAST_STEP) begin
				step_nxt = step_q + START_STEP;
			end else begin
				step_nxt      = '0;
				res.line_done = 1'b1;
			end
		end
		res.sensor_clock = clock_nxt;
		res.start_pulse  = start_nxt;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= 1'b0;
			start_q <= 1'b0;
			step_q  <= '0;
			mark_q  <= '0;
		end else if (step_en) begin
			clock_q <= clock_nxt;
			start_q <= start_nxt;
			step_q  <= step_nxt;
			mark_q  <= mark_nxt;
		end
	end

endmodule

FILE: hw/rtl/line_scan_camera_readout_core.sv
// Top level of the line scan camera readout core.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_stall     now_ms, adc_sample
//   result    out        result_valid / result_stall sensor_clock .. line_done
//   config    in         APB psel/penable/pready     frame_period_ms at 0x0
//
// Each item yields one result, held first in the input register and then in
// the result register. One item per cycle is taken sustained while the result
// is not stalled; the tick update is a single pass of logic on the sequencer state.
// arst_n clears the sequencer state, both valid flags and the period to 60.
// A stalled result holds the result register and, behind it, the input register;
// item_stall rises only when both are full.
module line_scan_camera_readout_core
	import lscr_pkg::*;
#(
	parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic [SAMPLE_W-1:0]   adc_sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  sensor_clock,
	output logic                  start_pulse,
	output logic                  pixel_valid,
	output logic [INDEX_W-1:0]    pixel_index,
	output logic [SAMPLE_W-1:0]   pixel_value,
	output logic                  line_done
);

	logic                vld_s1;
	logic [TIME_W-1:0]   now_ms_s1;
	logic [SAMPLE_W-1:0] adc_sample_s1;
	logic                res_vld_q;
	result_t             res_q;
	result_t             res_d;
	logic [TIME_W-1:0]   frame_period;
	logic                advance;
	logic                load_s1;

	// Pipeline control
	assign advance    = !res_vld_q || !result_stall;
	assign item_stall = vld_s1 && !advance;
	assign load_s1    = item_valid && !item_stall;

	lscr_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_period (frame_period)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance || !vld_s1) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			now_ms_s1     <= now_ms;
			adc_sample_s1 <= adc_sample;
		end
	end

	lscr_seq #(
		.PIXEL_COUNT (PIXEL_COUNT)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (vld_s1 && advance),
		.now_ms       (now_ms_s1),
		.adc_sample   (adc_sample_s1),
		.frame_period (frame_period),
		.res          (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_vld_q;
	assign sensor_clock = res_q.sensor_clock;
	assign start_pulse  = res_q.start_pulse;
	assign pixel_valid  = res_q.pixel_valid;
	assign pixel_index  = res_q.pixel_index;
	assign pixel_value  = res_q.pixel_value;
	assign line_done    = res_q.line_done;

endmodule

FILE: hw/rtl/lscr_checker.sv
// Port-level checks for the line scan camera readout core, bound to the top.
module lscr_checker
	import lscr_pkg::*;
#(
	parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_stall,
	input logic                sensor_clock,
	input logic                pixel_valid,
	input logic [INDEX_W-1:0]  pixel_index,
	input logic [SAMPLE_W-1:0] pixel_value,
	input logic                line_done
);

	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(PIXEL_COUNT - 1);

	// A stalled result stays offered and unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(sensor_clock)
			&& $stable(pixel_index) && $stable(pixel_value))
		else $error("stalled result changed");

	// Without a pixel the capture fields are zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !pixel_valid |->
			pixel_index == '0 && pixel_value == '0 && !line_done)
		else $error("capture fields set without a pixel");

	// Line end comes with the last pixel of the line
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && line_done |-> pixel_valid && pixel_index == LAST_INDEX)
		else $error("line done not on last pixel");

	// Pixels are captured only on ticks that drive the clock high
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pixel_valid |-> sensor_clock)
		else $error("pixel captured on wrong clock phase");

endmodule

bind line_scan_camera_readout_core lscr_checker #(
	.PIXEL_COUNT (PIXEL_COUNT)
) u_lscr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.sensor_clock (sensor_clock),
	.pixel_valid  (pixel_valid),
	.pixel_index  (pixel_index),
	.pixel_value  (pixel_value),
	.line_done    (line_done)
);
